// ===== hw/rtl/quadratic_probe_hash_table_defines.svh =====
// assertion helpers shared by the rtl files
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define QPHT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/qpht_pkg.sv =====
package qpht_pkg;

   localparam int SLOTS      = 64;
   localparam int KEY_BITS   = 31;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int SIZE_BITS  = $clog2(SLOTS + 1);
   localparam int CFG_BITS   = 7;
   localparam int CNT_BITS   = $clog2(KEY_BITS + 1);
   localparam int ENTRY_BITS = KEY_BITS + 2;

   typedef logic [1:0] tag_type;
   localparam tag_type TAG_EMPTY   = 2'd0;
   localparam tag_type TAG_USED    = 2'd1;
   localparam tag_type TAG_DELETED = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_FULL = 2'd2;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_SEARCH = 2'd1;
   localparam mode_type MODE_REMOVE = 2'd2;
   localparam mode_type MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic                 start;
      logic [KEY_BITS-1:0]  dividend;
      logic [SIZE_BITS-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic                 done;
      logic [SLOT_BITS-1:0] rem;
   } mod_rsp_type;

endpackage

// ===== hw/rtl/qpht_mod.sv =====
`include "quadratic_probe_hash_table_defines.svh"

module qpht_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  qpht_pkg::mod_req_type mod_req,
   output qpht_pkg::mod_rsp_type mod_rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [qpht_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [qpht_pkg::SLOT_BITS-1:0] rem_ff, rem_in;
   logic [qpht_pkg::KEY_BITS-1:0]  shift_ff, shift_in;
   logic [qpht_pkg::SIZE_BITS-1:0] divisor_ff, divisor_in;
   logic [qpht_pkg::SIZE_BITS-1:0] trial;

   // one quotient bit per cycle, remainder only
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, shift_ff[qpht_pkg::KEY_BITS-1]};
      if (mod_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = qpht_pkg::CNT_BITS'(qpht_pkg::KEY_BITS);
         rem_in     = '0;
         shift_in   = mod_req.dividend;
         divisor_in = mod_req.divisor;
      end else if (busy_ff) begin
         if (trial >= divisor_ff) begin
            rem_in = qpht_pkg::SLOT_BITS'(trial - divisor_ff);
         end else begin
            rem_in = qpht_pkg::SLOT_BITS'(trial);
         end
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == qpht_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

   `QPHT_ASSERT_NEXT(a_start_busy, mod_req.start, busy_ff, "divider did not start")
   `QPHT_ASSERT_NOW(a_rem_range, done_ff, qpht_pkg::SIZE_BITS'(rem_ff) < divisor_ff, "rem range")
   `QPHT_ASSERT_NOW(a_done_idle, done_ff, !busy_ff, "done while still busy")

endmodule

// ===== hw/rtl/quadratic_probe_hash_table.sv =====
// channel   dir  handshake                payload
// request   in   req_valid / req_ready    req_mode, req_key
// response  out  rsp_valid / rsp_ready    rsp_status
// csr       in   csr_we (no wait)         csr_wdata (table size)
//
// a request first gets its home slot from the bit-serial remainder unit (key mod table size),
// then probes (slot memory read, then check), up to table size probes, then responds
// mode 3 skips the remainder unit and the probes and answers with a miss
// reset empties the table at once through per-slot valid bits, no sweep
// a new request is taken while a response waits; the next response holds until taken
`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_mode,
   input  logic [qpht_pkg::KEY_BITS-1:0]  req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_we,
   input  logic [qpht_pkg::CFG_BITS-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_PROBE = 5'b00100,
      S_CHECK = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [qpht_pkg::SIZE_BITS-1:0]     size_ff, size_in;
   logic [qpht_pkg::KEY_BITS-1:0]      key_ff, key_in;
   qpht_pkg::mode_type                 mode_ff, mode_in;
   logic [qpht_pkg::SLOT_BITS-1:0]     slot_ff, slot_in;
   logic [qpht_pkg::SLOT_BITS-1:0]     step_ff, step_in;
   logic [qpht_pkg::SIZE_BITS-1:0]     idx_ff, idx_in;
   qpht_pkg::status_type               result_ff, result_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   qpht_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [qpht_pkg::SLOTS-1:0]         valid_ff;
   logic [qpht_pkg::ENTRY_BITS-1:0]    mem_ff [qpht_pkg::SLOTS];
   logic [qpht_pkg::ENTRY_BITS-1:0]    rd_data_ff;
   logic                               rd_valid_ff;
   logic                               wr_en;
   qpht_pkg::tag_type                  wr_tag;
   qpht_pkg::tag_type                  rd_tag;
   logic                               rd_hit;
   logic [qpht_pkg::SIZE_BITS-1:0]     slot_sum;
   logic [qpht_pkg::SIZE_BITS-1:0]     step_sum;
   logic                               req_acc;
   qpht_pkg::mod_req_type              mod_req;
   qpht_pkg::mod_rsp_type              mod_rsp;

   qpht_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_acc    = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   assign mod_req.start    = req_acc && (req_mode != qpht_pkg::MODE_UNUSED);
   assign mod_req.dividend = req_key;
   assign mod_req.divisor  = size_ff;

   // never-written slots read as empty
   assign rd_tag   = rd_valid_ff ? rd_data_ff[qpht_pkg::ENTRY_BITS-1 -: 2] : qpht_pkg::TAG_EMPTY;
   assign rd_hit   = (rd_tag == qpht_pkg::TAG_USED) &&
                     (rd_data_ff[qpht_pkg::KEY_BITS-1:0] == key_ff);
   assign slot_sum = {1'b0, slot_ff} + {1'b0, step_ff};
   assign step_sum = {1'b0, step_ff} + qpht_pkg::SIZE_BITS'(2);

   always_comb begin
      size_in = size_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            size_in = qpht_pkg::SIZE_BITS'(1);
         end else if (csr_wdata > qpht_pkg::CFG_BITS'(qpht_pkg::SLOTS)) begin
            size_in = qpht_pkg::SIZE_BITS'(qpht_pkg::SLOTS);
         end else begin
            size_in = qpht_pkg::SIZE_BITS'(csr_wdata);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_tag        = qpht_pkg::TAG_USED;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               key_in  = req_key;
               mode_in = req_mode;
               if (req_mode == qpht_pkg::MODE_UNUSED) begin
                  result_in = qpht_pkg::ST_MISS;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (mod_rsp.done) begin
               slot_in  = mod_rsp.rem;
               step_in  = (size_ff == qpht_pkg::SIZE_BITS'(1)) ? '0 : qpht_pkg::SLOT_BITS'(1);
               idx_in   = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (mode_ff == qpht_pkg::MODE_INSERT) begin
               if (rd_tag == qpht_pkg::TAG_EMPTY || rd_tag == qpht_pkg::TAG_DELETED) begin
                  wr_en     = 1'b1;
                  wr_tag    = qpht_pkg::TAG_USED;
                  result_in = qpht_pkg::ST_OK;
                  state_in  = S_DONE;
               end
            end else if (rd_tag == qpht_pkg::TAG_EMPTY) begin
               result_in = qpht_pkg::ST_MISS;
               state_in  = S_DONE;
            end else if (rd_hit) begin
               wr_en     = (mode_ff == qpht_pkg::MODE_REMOVE);
               wr_tag    = qpht_pkg::TAG_DELETED;
               result_in = qpht_pkg::ST_OK;
               state_in  = S_DONE;
            end
            if (state_in == S_CHECK) begin
               if (idx_ff == size_ff - 1'b1) begin
                  result_in = (mode_ff == qpht_pkg::MODE_INSERT) ? qpht_pkg::ST_FULL
                                                                 : qpht_pkg::ST_MISS;
                  state_in  = S_DONE;
               end else begin
                  // slot += 2i+1, step += 2, both mod size
                  slot_in  = qpht_pkg::SLOT_BITS'((slot_sum >= size_ff) ? slot_sum - size_ff
                                                                         : slot_sum);
                  step_in  = qpht_pkg::SLOT_BITS'((step_sum >= size_ff) ? step_sum - size_ff
                                                                         : step_sum);
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_PROBE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = result_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= qpht_pkg::SIZE_BITS'(qpht_pkg::SLOTS);
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[slot_ff] <= 1'b1;
         end
      end
      key_ff        <= key_in;
      mode_ff       <= mode_in;
      slot_ff       <= slot_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
   end

   // slot memory: one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[slot_ff] <= {wr_tag, key_ff};
      end
      if (state_ff == S_PROBE) begin
         rd_data_ff  <= mem_ff[slot_ff];
         rd_valid_ff <= valid_ff[slot_ff];
      end
   end

   `QPHT_ASSERT_NEXT(a_accept_busy, req_acc, state_ff != S_IDLE, "request accepted but idle")
   `QPHT_ASSERT_NOW(a_slot_range, state_ff == S_CHECK, qpht_pkg::SIZE_BITS'(slot_ff) < size_ff, "slot")
   `QPHT_ASSERT_NOW(a_idx_range, state_ff == S_CHECK, idx_ff < size_ff, "probe count beyond table size")
   `QPHT_ASSERT_NOW(a_wr_state, wr_en, state_ff == S_CHECK, "slot write outside check")

endmodule
